/* rtl/core/antialiased_line_raster_macros.svh */
// Assertion macros for the antialiased line rasterizer.
`ifndef ANTIALIASED_LINE_RASTER_MACROS_SVH
`define ANTIALIASED_LINE_RASTER_MACROS_SVH

// Check a consequence in the same cycle.
`define ALR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a consequence in the following cycle.
`define ALR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/alr_pkg.sv */
// Shared constants, codes and control types of the line rasterizer.
package alr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int COLOR_BITS     = 24;
    localparam int CHAN_BITS      = 8;
    localparam int NUM_CHANS      = 3;

    localparam logic [COLOR_BITS-1:0] SENTINEL_RESET = 24'hFA9284;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_COLUMN = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic column;
        logic div_step;
        logic div_finish;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_status;

endpackage

/* rtl/core/alr_channels.sv */
// Request channel interfaces: line and column requests, pixel pairs, configuration.
interface alr_line_if #(
    parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF
);
    logic                                 valid;
    logic                                 ready;
    logic                                 mode;
    logic signed [COORD_BITS-1:0]         start_x;
    logic signed [COORD_BITS-1:0]         start_y;
    logic signed [COORD_BITS-1:0]         end_x;
    logic signed [COORD_BITS-1:0]         end_y;
    logic [alr_pkg::COLOR_BITS-1:0]       start_color;
    logic [alr_pkg::COLOR_BITS-1:0]       end_color;

    modport source (
        output valid, mode, start_x, start_y, end_x, end_y, start_color, end_color,
        input  ready
    );
    modport sink (
        input  valid, mode, start_x, start_y, end_x, end_y, start_color, end_color,
        output ready
    );
endinterface

interface alr_pix_if #(
    parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF
);
    logic                                 valid;
    logic                                 ready;
    logic signed [COORD_BITS-1:0]         lower_px_x;
    logic signed [COORD_BITS-1:0]         lower_px_y;
    logic [alr_pkg::COLOR_BITS-1:0]       lower_color;
    logic signed [COORD_BITS-1:0]         upper_px_x;
    logic signed [COORD_BITS-1:0]         upper_px_y;
    logic [alr_pkg::COLOR_BITS-1:0]       upper_color;
    logic                                 last_column;

    modport source (
        output valid, lower_px_x, lower_px_y, lower_color,
               upper_px_x, upper_px_y, upper_color, last_column,
        input  ready
    );
    modport sink (
        input  valid, lower_px_x, lower_px_y, lower_color,
               upper_px_x, upper_px_y, upper_color, last_column,
        output ready
    );
endinterface

interface alr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [alr_pkg::COLOR_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* rtl/core/antialiased_line_raster.sv */
// Antialiased line rasterizer top level: one pixel pair per column request.
//
// i_line carries requests: mode 0 loads a line (two endpoints, two colors),
// mode 1 asks for the next column. o_pix returns one pixel pair per column
// request while a line is active; a column request with no active line is
// taken and dropped. i_cfg writes the sentinel color and is always ready.
// A load is accepted, then runs the bit-serial gradient divider (one quotient
// bit per cycle) and its finish step before i_line is ready again.
// A column request is answered in the cycle after acceptance from the output
// register; columns sustain one per cycle while o_pix is drained.
// If o_pix stalls, the held pair stays put and i_line drops ready until the
// output register is taken. Synchronous reset clears control state, returns
// the block to idle with no line active and restores the sentinel color.
// The last column of a line is flagged with last_column.
`include "antialiased_line_raster_macros.svh"

module antialiased_line_raster #(
    parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = alr_pkg::FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    alr_line_if.sink  i_line,
    alr_pix_if.source o_pix,
    alr_cfg_if.sink   i_cfg
);

    alr_pkg::t_cmd    cmd;
    alr_pkg::t_status status;

    assign i_cfg.ready = 1'b1;

    alr_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_line.valid),
        .i_in_mode   (i_line.mode),
        .o_in_ready  (i_line.ready),
        .i_out_ready (o_pix.ready),
        .o_out_valid (o_pix.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    alr_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg.valid && i_cfg.ready),
        .i_cfg_data    (i_cfg.data),
        .i_start_x     (i_line.start_x),
        .i_start_y     (i_line.start_y),
        .i_end_x       (i_line.end_x),
        .i_end_y       (i_line.end_y),
        .i_start_color (i_line.start_color),
        .i_end_color   (i_line.end_color),
        .o_lower_px_x  (o_pix.lower_px_x),
        .o_lower_px_y  (o_pix.lower_px_y),
        .o_lower_color (o_pix.lower_color),
        .o_upper_px_x  (o_pix.upper_px_x),
        .o_upper_px_y  (o_pix.upper_px_y),
        .o_upper_color (o_pix.upper_color),
        .o_last_column (o_pix.last_column)
    );

    `ALR_ASSERT_NEXT(a_load_blocks_input, i_line.valid && i_line.ready && i_line.mode == alr_pkg::MODE_LOAD, !i_line.ready, "input ready right after a line load")
    `ALR_ASSERT_SAME(a_column_slot_free, cmd.column, !o_pix.valid || o_pix.ready, "column emitted over an untaken pixel pair")
    `ALR_ASSERT_NEXT(a_column_gives_valid, cmd.column, o_pix.valid, "column emitted without output valid")

endmodule

/* rtl/core/alr_ctrl.sv */
// Controller: request acceptance, gradient division sequencing, output valid.
module alr_ctrl #(
    parameter int FRAC_BITS = alr_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_mode,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  alr_pkg::t_status i_status,
    output alr_pkg::t_cmd    o_cmd
);

    localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

    alr_pkg::t_state     r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_drawing, n_drawing;
    logic                r_out_valid, n_out_valid;
    logic                in_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= alr_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_drawing   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_drawing   <= n_drawing;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_drawing   = r_drawing;
        n_out_valid = r_out_valid;
        o_in_ready  = 1'b0;
        in_acc      = 1'b0;
        o_cmd       = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            alr_pkg::ST_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
                in_acc     = i_in_valid && o_in_ready;
                if (in_acc && i_in_mode == alr_pkg::MODE_LOAD) begin
                    o_cmd.load = 1'b1;
                    n_drawing  = 1'b1;
                    n_cnt      = CNT_BITS'(FRAC_BITS);
                    n_state    = alr_pkg::ST_DIVIDE;
                end else if (in_acc && i_in_mode == alr_pkg::MODE_COLUMN && r_drawing) begin
                    o_cmd.column = 1'b1;
                    n_out_valid  = 1'b1;
                    if (i_status.last) begin
                        n_drawing = 1'b0;
                    end
                end
            end
            alr_pkg::ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = alr_pkg::ST_FINISH;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            alr_pkg::ST_FINISH: begin
                o_cmd.div_finish = 1'b1;
                n_state          = alr_pkg::ST_IDLE;
            end
            default: begin
                n_state = alr_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/core/alr_datapath.sv */
// Datapath: line setup, bit-serial gradient divider, column stepping and weighting.
module alr_datapath #(
    parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = alr_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  alr_pkg::t_cmd                      i_cmd,
    output alr_pkg::t_status                   o_status,
    input  logic                               i_cfg_we,
    input  logic [alr_pkg::COLOR_BITS-1:0]     i_cfg_data,
    input  logic signed [COORD_BITS-1:0]       i_start_x,
    input  logic signed [COORD_BITS-1:0]       i_start_y,
    input  logic signed [COORD_BITS-1:0]       i_end_x,
    input  logic signed [COORD_BITS-1:0]       i_end_y,
    input  logic [alr_pkg::COLOR_BITS-1:0]     i_start_color,
    input  logic [alr_pkg::COLOR_BITS-1:0]     i_end_color,
    output logic signed [COORD_BITS-1:0]       o_lower_px_x,
    output logic signed [COORD_BITS-1:0]       o_lower_px_y,
    output logic [alr_pkg::COLOR_BITS-1:0]     o_lower_color,
    output logic signed [COORD_BITS-1:0]       o_upper_px_x,
    output logic signed [COORD_BITS-1:0]       o_upper_px_y,
    output logic [alr_pkg::COLOR_BITS-1:0]     o_upper_color,
    output logic                               o_last_column
);

    localparam int POS_BITS = COORD_BITS + FRAC_BITS;
    localparam int REM_BITS = COORD_BITS + 2;
    localparam int DEN_BITS = COORD_BITS + 1;
    localparam int Q_BITS   = FRAC_BITS + 1;
    localparam int CB       = alr_pkg::CHAN_BITS;

    logic [alr_pkg::COLOR_BITS-1:0] r_sentinel;

    logic signed [COORD_BITS-1:0]   r_col_x;
    logic signed [COORD_BITS-1:0]   r_final_x;
    logic [POS_BITS-1:0]            r_minor;
    logic [POS_BITS-1:0]            r_slope;
    logic                           r_steep;
    logic [alr_pkg::COLOR_BITS-1:0] r_color;
    logic [REM_BITS-1:0]            r_rem;
    logic [DEN_BITS-1:0]            r_den;
    logic [Q_BITS-1:0]              r_quot;
    logic                           r_neg;
    logic                           r_dx_zero;

    logic signed [COORD_BITS-1:0]   r_lo_x, r_lo_y, r_hi_x, r_hi_y;
    logic [alr_pkg::COLOR_BITS-1:0] r_lo_color, r_hi_color;
    logic                           r_last;

    // line setup
    logic [DEN_BITS-1:0]          raw_dx, raw_dy, abs_dx, abs_dy;
    logic                         steep, swap;
    logic signed [COORD_BITS-1:0] p0x, p0y, p1x, p1y, sx, sy, ex, ey;
    logic [DEN_BITS-1:0]          dx, dy, abs_dy_line;

    assign raw_dx = {i_end_x[COORD_BITS-1], i_end_x} - {i_start_x[COORD_BITS-1], i_start_x};
    assign raw_dy = {i_end_y[COORD_BITS-1], i_end_y} - {i_start_y[COORD_BITS-1], i_start_y};
    assign abs_dx = raw_dx[DEN_BITS-1] ? -raw_dx : raw_dx;
    assign abs_dy = raw_dy[DEN_BITS-1] ? -raw_dy : raw_dy;
    assign steep  = abs_dy > abs_dx;

    assign p0x  = steep ? i_start_y : i_start_x;
    assign p0y  = steep ? i_start_x : i_start_y;
    assign p1x  = steep ? i_end_y   : i_end_x;
    assign p1y  = steep ? i_end_x   : i_end_y;
    assign swap = p0x > p1x;
    assign sx   = swap ? p1x : p0x;
    assign sy   = swap ? p1y : p0y;
    assign ex   = swap ? p0x : p1x;
    assign ey   = swap ? p0y : p1y;

    assign dx          = {ex[COORD_BITS-1], ex} - {sx[COORD_BITS-1], sx};
    assign dy          = {ey[COORD_BITS-1], ey} - {sy[COORD_BITS-1], sy};
    assign abs_dy_line = dy[DEN_BITS-1] ? -dy : dy;

    // divider step
    logic [REM_BITS-1:0] rem_diff;
    logic                rem_ge;

    assign rem_ge   = r_rem >= {1'b0, r_den};
    assign rem_diff = r_rem - {1'b0, r_den};

    // gradient result
    logic [POS_BITS-1:0] quot_ext, slope_val;

    assign quot_ext  = {{(POS_BITS-Q_BITS){1'b0}}, r_quot};
    assign slope_val = r_dx_zero ? {{(COORD_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}}
                     : (r_neg ? -quot_ext : quot_ext);

    // column pair
    logic                         iny_neg, frac_nz, lo_keep;
    logic [FRAC_BITS-1:0]         iny_low, frac;
    logic signed [COORD_BITS-1:0] iny_int, hi_c, lo_c;
    logic [Q_BITS-1:0]            w_frac, w_rest, w_lo, w_hi;
    logic [alr_pkg::COLOR_BITS-1:0] lo_scaled, hi_scaled;

    assign iny_neg = r_minor[POS_BITS-1];
    assign iny_low = r_minor[FRAC_BITS-1:0];
    assign iny_int = r_minor[POS_BITS-1:FRAC_BITS];
    assign frac_nz = |iny_low;
    assign frac    = iny_neg ? -iny_low : iny_low;
    assign hi_c    = iny_int + {{(COORD_BITS-1){1'b0}}, iny_neg && frac_nz};
    assign lo_keep = (iny_neg || iny_int == '0) && frac_nz;
    assign lo_c    = lo_keep ? iny_int : iny_int - 1'b1;

    assign w_frac = {1'b0, frac};
    assign w_rest = {1'b1, {FRAC_BITS{1'b0}}} - w_frac;
    assign w_lo   = iny_neg ? w_frac : w_rest;
    assign w_hi   = iny_neg ? w_rest : w_frac;

    for (genvar ch = 0; ch < alr_pkg::NUM_CHANS; ch++) begin : g_chan
        logic [CB+Q_BITS-1:0] prod_lo, prod_hi;
        assign prod_lo = {{Q_BITS{1'b0}}, r_color[ch*CB +: CB]} * {{CB{1'b0}}, w_lo};
        assign prod_hi = {{Q_BITS{1'b0}}, r_color[ch*CB +: CB]} * {{CB{1'b0}}, w_hi};
        assign lo_scaled[ch*CB +: CB] = prod_lo[FRAC_BITS +: CB];
        assign hi_scaled[ch*CB +: CB] = prod_hi[FRAC_BITS +: CB];
    end

    assign o_status.last = r_col_x == r_final_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sentinel <= alr_pkg::SENTINEL_RESET;
        end else if (i_cfg_we) begin
            r_sentinel <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col_x   <= sx;
            r_final_x <= ex;
            r_minor   <= {sy, {FRAC_BITS{1'b0}}};
            r_steep   <= steep;
            r_color   <= (i_start_color == r_sentinel) ? i_end_color : i_start_color;
            r_rem     <= {1'b0, abs_dy_line};
            r_den     <= dx;
            r_quot    <= '0;
            r_neg     <= dy[DEN_BITS-1];
            r_dx_zero <= dx == '0;
        end else if (i_cmd.div_step) begin
            r_quot <= {r_quot[Q_BITS-2:0], rem_ge};
            r_rem  <= rem_ge ? {rem_diff[REM_BITS-2:0], 1'b0} : {r_rem[REM_BITS-2:0], 1'b0};
        end else if (i_cmd.div_finish) begin
            r_slope <= slope_val;
        end else if (i_cmd.column) begin
            r_col_x <= r_col_x + 1'b1;
            r_minor <= r_minor + r_slope;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.column) begin
            r_lo_x     <= r_steep ? lo_c : r_col_x;
            r_lo_y     <= r_steep ? r_col_x : lo_c;
            r_hi_x     <= r_steep ? hi_c : r_col_x;
            r_hi_y     <= r_steep ? r_col_x : hi_c;
            r_lo_color <= lo_scaled;
            r_hi_color <= hi_scaled;
            r_last     <= o_status.last;
        end
    end

    assign o_lower_px_x  = r_lo_x;
    assign o_lower_px_y  = r_lo_y;
    assign o_lower_color = r_lo_color;
    assign o_upper_px_x  = r_hi_x;
    assign o_upper_px_y  = r_hi_y;
    assign o_upper_color = r_hi_color;
    assign o_last_column = r_last;

endmodule

/* test/antialiased_line_raster_checker.sv */
// Checker for the line rasterizer: predicts each pixel pair and compares it with the output.
`timescale 1ns / 100ps
module antialiased_line_raster_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    alr_line_if  line_mon,
    alr_pix_if   pix_mon,
    alr_cfg_if   cfg_mon,
    output int   o_fail_count,
    output int   o_pending
);
    localparam int     CB      = alr_pkg::COORD_BITS_DEF;
    localparam int     FB      = alr_pkg::FRAC_BITS_DEF;
    localparam int     PB      = CB + FB;
    localparam int     CW      = alr_pkg::COLOR_BITS;
    localparam int     CHB     = alr_pkg::CHAN_BITS;
    localparam longint FIX_ONE = longint'(1) << FB;

    typedef struct packed {
        logic [CB-1:0] lower_x;
        logic [CB-1:0] lower_y;
        logic [CW-1:0] lower_color;
        logic [CB-1:0] upper_x;
        logic [CB-1:0] upper_y;
        logic [CW-1:0] upper_color;
        logic          last;
    } t_pixel_pair;

    t_pixel_pair   expected_pairs[$];
    logic [CW-1:0] sentinel_color;
    logic [CW-1:0] line_color;
    logic [CB-1:0] column_x;
    logic [CB-1:0] final_x;
    logic [PB-1:0] minor_pos;
    logic [PB-1:0] slope;
    logic          steep;
    logic          drawing;
    int            fails = 0;

    assign o_fail_count = fails;

    function automatic longint toward_zero(longint v);
        return (v >= 0) ? (v >>> FB) : -((-v) >>> FB);
    endfunction

    function automatic logic [CW-1:0] weigh_color(logic [CW-1:0] c, longint w);
        logic [CW-1:0] r;
        longint        ch;
        r = '0;
        for (int i = 0; i < alr_pkg::NUM_CHANS; i++) begin
            ch = longint'(c[i*CHB +: CHB]);
            ch = (ch * w) >>> FB;
            r[i*CHB +: CHB] = ch[CHB-1:0];
        end
        return r;
    endfunction

    task automatic load_line(input logic [CB-1:0] sx, sy, ex, ey,
                             input logic [CW-1:0] sc, ec);
        longint ax, ay, bx, by, t, dx, dy, grad, base;
        ax = longint'($signed(sx));
        ay = longint'($signed(sy));
        bx = longint'($signed(ex));
        by = longint'($signed(ey));
        dx = bx - ax;
        dy = by - ay;
        steep = ((dy < 0) ? -dy : dy) > ((dx < 0) ? -dx : dx);
        if (steep) begin
            t = ax; ax = ay; ay = t;
            t = bx; bx = by; by = t;
        end
        if (ax > bx) begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
        end
        dx = bx - ax;
        dy = by - ay;
        grad = (dx == 0) ? FIX_ONE : (dy * FIX_ONE) / dx;
        base = ay * FIX_ONE;
        slope = grad[PB-1:0];
        minor_pos = base[PB-1:0];
        column_x = ax[CB-1:0];
        final_x = bx[CB-1:0];
        line_color = (sc == sentinel_color) ? ec : sc;
        drawing = 1'b1;
    endtask

    task automatic predict_column(output t_pixel_pair p);
        longint iny, mag, frac, w_lo, w_hi, w_t, lo, hi;
        logic   at_end;
        iny = longint'($signed(minor_pos));
        mag = (iny < 0) ? -iny : iny;
        frac = mag & (FIX_ONE - 1);
        w_lo = FIX_ONE - frac;
        w_hi = frac;
        lo = toward_zero(iny - FIX_ONE);
        hi = toward_zero(iny);
        at_end = (column_x == final_x);
        if (iny < 0) begin
            w_t = w_lo; w_lo = w_hi; w_hi = w_t;
        end
        if (steep) begin
            p.lower_x = lo[CB-1:0];
            p.lower_y = column_x;
            p.upper_x = hi[CB-1:0];
            p.upper_y = column_x;
        end else begin
            p.lower_x = column_x;
            p.lower_y = lo[CB-1:0];
            p.upper_x = column_x;
            p.upper_y = hi[CB-1:0];
        end
        p.lower_color = weigh_color(line_color, w_lo);
        p.upper_color = weigh_color(line_color, w_hi);
        p.last = at_end;
        column_x = column_x + 1'b1;
        minor_pos = minor_pos + slope;
        if (at_end) begin
            drawing = 1'b0;
        end
    endtask

    task automatic compare_field(input string name, input logic [CW-1:0] want, got);
        if (got !== want) begin
            $error("%s: expected %h, actual %h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel_pair want;
        if (!i_rst_n) begin
            expected_pairs.delete();
            sentinel_color = alr_pkg::SENTINEL_RESET;
            line_color = '0;
            column_x = '0;
            final_x = '0;
            minor_pos = '0;
            slope = '0;
            steep = 1'b0;
            drawing = 1'b0;
        end else begin
            if (pix_mon.valid && pix_mon.ready) begin
                if (expected_pairs.size() == 0) begin
                    $error("pixel pair with no request waiting");
                    fails++;
                end else begin
                    want = expected_pairs.pop_front();
                    compare_field("lower_px_x", want.lower_x, $unsigned(pix_mon.lower_px_x));
                    compare_field("lower_px_y", want.lower_y, $unsigned(pix_mon.lower_px_y));
                    compare_field("lower_color", want.lower_color, pix_mon.lower_color);
                    compare_field("upper_px_x", want.upper_x, $unsigned(pix_mon.upper_px_x));
                    compare_field("upper_px_y", want.upper_y, $unsigned(pix_mon.upper_px_y));
                    compare_field("upper_color", want.upper_color, pix_mon.upper_color);
                    compare_field("last_column", want.last, pix_mon.last_column);
                end
            end
            if (cfg_mon.valid && cfg_mon.ready) begin
                sentinel_color = cfg_mon.data;
            end
            if (line_mon.valid && line_mon.ready) begin
                if (line_mon.mode == alr_pkg::MODE_LOAD) begin
                    load_line($unsigned(line_mon.start_x), $unsigned(line_mon.start_y),
                              $unsigned(line_mon.end_x), $unsigned(line_mon.end_y),
                              line_mon.start_color, line_mon.end_color);
                end else if (drawing) begin
                    predict_column(want);
                    expected_pairs.push_back(want);
                end
            end
        end
        o_pending <= expected_pairs.size();
    end
endmodule

/* test/antialiased_line_raster_tb.sv */
// Testbench top for the line rasterizer: clock, reset, requests, stalls and verdict.
`timescale 1ns / 100ps
module antialiased_line_raster_tb;

    localparam int CB            = alr_pkg::COORD_BITS_DEF;
    localparam int CW            = alr_pkg::COLOR_BITS;
    localparam int COORD_MIN     = -(1 << (CB - 1));
    localparam int COORD_MAX     = (1 << (CB - 1)) - 1;
    localparam int COORD_SPAN    = (1 << CB) - 1;
    localparam int PHASE_ITEMS   = 300;
    localparam int SETTLE_CYCLES = alr_pkg::FRAC_BITS_DEF + 8;
    localparam int CYCLE_LIMIT   = 600000;

    logic          clk = 1'b0;
    logic          rst_n;
    int            idle_pct = 0;
    int            stall_pct = 0;
    int            cycles = 0;
    int            requests = 0;
    int            fail_count;
    int            pending;
    logic [CW-1:0] sentinel = alr_pkg::SENTINEL_RESET;

    alr_line_if line_if ();
    alr_pix_if  pix_if ();
    alr_cfg_if  cfg_if ();

    antialiased_line_raster dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_line  (line_if.sink),
        .o_pix   (pix_if.source),
        .i_cfg   (cfg_if.sink)
    );

    antialiased_line_raster_checker line_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .line_mon     (line_if),
        .pix_mon      (pix_if),
        .cfg_mon      (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        pix_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(input logic mode, input int sx, sy, ex, ey,
                             input logic [CW-1:0] sc, ec);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            line_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        line_if.valid <= 1'b1;
        line_if.mode <= mode;
        line_if.start_x <= sx[CB-1:0];
        line_if.start_y <= sy[CB-1:0];
        line_if.end_x <= ex[CB-1:0];
        line_if.end_y <= ey[CB-1:0];
        line_if.start_color <= sc;
        line_if.end_color <= ec;
        do @(posedge clk); while (line_if.ready !== 1'b1);
    endtask

    task automatic send_columns(input int n);
        repeat (n) send_item(alr_pkg::MODE_COLUMN, $urandom, $urandom, $urandom, $urandom,
                             CW'($urandom), CW'($urandom));
    endtask

    task automatic send_line(input int sx, sy, ex, ey, input logic [CW-1:0] sc, ec,
                             input int shown);
        send_item(alr_pkg::MODE_LOAD, sx, sy, ex, ey, sc, ec);
        send_columns(shown);
        requests += 1 + shown;
    endtask

    // Hold requests until every pixel pair is out and the divider is done.
    task automatic pause_line();
        line_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sentinel(input logic [CW-1:0] value);
        pause_line();
        cfg_if.valid <= 1'b1;
        cfg_if.data <= value;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        sentinel = value;
    endtask

    function automatic int line_columns(int sx, sy, ex, ey);
        int ax, ay;
        ax = (ex > sx) ? ex - sx : sx - ex;
        ay = (ey > sy) ? ey - sy : sy - ey;
        return ((ax > ay) ? ax : ay) + 1;
    endfunction

    function automatic int clamp_coord(int v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(COORD_SPAN)) + COORD_MIN;
    endfunction

    function automatic logic [CW-1:0] pick_color();
        case ($urandom_range(9))
            0, 1: return sentinel;
            2: return '0;
            3: return '1;
            default: return CW'($urandom);
        endcase
    endfunction

    // Mostly short complete lines; some abandoned, some long and cut short.
    task automatic random_line();
        int kind, sx, sy, ex, ey, span, total, shown;
        kind = $urandom_range(99);
        sx = any_coord();
        sy = any_coord();
        if (kind < 90) begin
            span = ($urandom_range(9) == 0) ? 160 : 12;
            ex = clamp_coord(sx + int'($urandom_range(2 * span)) - span);
            ey = clamp_coord(sy + int'($urandom_range(2 * span)) - span);
        end else begin
            ex = any_coord();
            ey = any_coord();
        end
        total = line_columns(sx, sy, ex, ey);
        if (kind >= 90) begin
            shown = $urandom_range(40);
        end else if ($urandom_range(99) < 8) begin
            shown = $urandom_range(total - 1);
        end else begin
            shown = total;
        end
        if (shown > total) begin
            shown = total;
        end
        send_line(sx, sy, ex, ey, pick_color(), pick_color(), shown);
        if (shown == total && $urandom_range(99) < 12) begin
            send_columns($urandom_range(3, 1));
        end
    endtask

    initial begin
        int target;
        rst_n <= 1'b0;
        line_if.valid <= 1'b0;
        line_if.mode <= alr_pkg::MODE_LOAD;
        line_if.start_x <= '0;
        line_if.start_y <= '0;
        line_if.end_x <= '0;
        line_if.end_y <= '0;
        line_if.start_color <= '0;
        line_if.end_color <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_columns(1);
        send_line(COORD_MIN, COORD_MIN, COORD_MIN + 1, COORD_MIN, alr_pkg::SENTINEL_RESET,
                  24'hFFFFFF, 2);
        send_line(COORD_MAX, COORD_MAX, COORD_MAX - 1, COORD_MAX, 24'h000000,
                  24'hABCDEF, 2);
        send_line(-5, -100, -7, -97, 24'hFFFFFF, 24'h000000, 4);
        send_line(10, 10, 10, 10, 24'h80FF01, 24'h123456, 1);
        send_columns(1);
        send_line(0, 0, 100, 37, 24'h55AA33, 24'h000000, 2);
        send_line(3, -1, -1, 2, 24'h0F0F0F, 24'h000000, 5);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                    write_sentinel('0);
                end
                1: begin
                    idle_pct = 75;
                    stall_pct = 0;
                    write_sentinel('1);
                end
                2: begin
                    idle_pct = 0;
                    stall_pct = 75;
                    write_sentinel(CW'($urandom));
                end
                default: begin
                    idle_pct = 18;
                    stall_pct = 18;
                    write_sentinel(alr_pkg::SENTINEL_RESET);
                end
            endcase
            target = requests + PHASE_ITEMS;
            while (requests < target) random_line();
        end

        pause_line();
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/alr_pkg.sv
rtl/core/alr_channels.sv
rtl/core/alr_ctrl.sv
rtl/core/alr_datapath.sv
rtl/core/antialiased_line_raster.sv
test/antialiased_line_raster_checker.sv
test/antialiased_line_raster_tb.sv
